// ===== design/bmpg_pkg.sv =====
package bmpg_pkg;

  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 768;
  localparam int unsigned PACKET_BYTES = 64;
  localparam int unsigned HEADER_BYTES = 54;

  localparam int unsigned PIXEL_BYTES = IMAGE_WIDTH * IMAGE_HEIGHT * 3;
  localparam int unsigned FILE_BYTES  = HEADER_BYTES + PIXEL_BYTES;

  localparam int unsigned LEN_BITS = 7;
  localparam int unsigned POS_BITS = $clog2(FILE_BYTES + 1);
  localparam int unsigned COL_BITS = $clog2(IMAGE_WIDTH);
  localparam int unsigned ROW_BITS = $clog2(IMAGE_HEIGHT);

  // The gradients step by a fixed quotient and remainder, blue per column and green per row.
  localparam int unsigned BLUE_Q    = 255 / (IMAGE_WIDTH - 1);
  localparam int unsigned BLUE_R    = 255 % (IMAGE_WIDTH - 1);
  localparam int unsigned GREEN_Q   = 255 / (IMAGE_HEIGHT - 1);
  localparam int unsigned GREEN_R   = 255 % (IMAGE_HEIGHT - 1);
  localparam int unsigned BREM_BITS = $clog2(IMAGE_WIDTH);
  localparam int unsigned GREM_BITS = $clog2(IMAGE_HEIGHT);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic                restart;
    logic [LEN_BITS-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic                busy;
    logic [POS_BITS-1:0] pos;
  } back_status_t;

  function automatic logic [7:0] header_byte(input logic [5:0] off);
    logic [5:0]  rel;
    logic [31:0] word;
    logic [7:0]  b;
    rel  = off - 6'd2;
    word = '0;
    b    = '0;
    if (off == 6'd0) begin
      b = "B";
    end else if (off == 6'd1) begin
      b = "M";
    end else if (off < 6'd26) begin
      case (rel[5:2])
        4'd0:    word = 32'(FILE_BYTES);
        4'd2:    word = 32'(HEADER_BYTES);
        4'd3:    word = 32'd40;
        4'd4:    word = 32'(IMAGE_WIDTH);
        4'd5:    word = 32'(IMAGE_HEIGHT);
        default: word = '0;
      endcase
      b = word[{rel[1:0], 3'b000} +: 8];
    end else if (off == 6'd26) begin
      b = 8'd1;
    end else if (off == 6'd28) begin
      b = 8'd24;
    end else if (off >= 6'd34 && off < 6'd38) begin
      word = 32'(PIXEL_BYTES);
      b    = word[{rel[1:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

// ===== design/bmpg_front.sv =====
module bmpg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  input  logic [bmpg_pkg::LEN_BITS-1:0] in_len,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output bmpg_pkg::cmd_t                cmd
);

  logic hold_valid;

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Requests above one packet are clipped to a packet.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.restart <= in_restart;
      if (in_len > bmpg_pkg::LEN_BITS'(bmpg_pkg::PACKET_BYTES)) begin
        cmd.len <= bmpg_pkg::LEN_BITS'(bmpg_pkg::PACKET_BYTES);
      end else begin
        cmd.len <= in_len;
      end
    end
  end

endmodule

// ===== design/bmpg_queue.sv =====
module bmpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  bmpg_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output bmpg_pkg::cmd_t rd_data
);

  bmpg_pkg::cmd_t                     mem [bmpg_pkg::QUEUE_DEPTH];
  logic [bmpg_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [bmpg_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [bmpg_pkg::QCNT_BITS-1:0]     count;
  logic                               push;
  logic                               pop;

  assign wr_ready = count != bmpg_pkg::QCNT_BITS'(bmpg_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bmpg_pkg::QPTR_BITS'(bmpg_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bmpg_pkg::QPTR_BITS'(bmpg_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/bmpg_back.sv =====
module bmpg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  bmpg_pkg::cmd_t               cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_byte,
  output logic                         out_last,
  output logic                         out_eof,
  output bmpg_pkg::back_status_t       status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;

  localparam int unsigned PB = bmpg_pkg::POS_BITS;
  localparam int unsigned CB = bmpg_pkg::COL_BITS;
  localparam int unsigned RB = bmpg_pkg::ROW_BITS;
  localparam int unsigned BB = bmpg_pkg::BREM_BITS;
  localparam int unsigned GB = bmpg_pkg::GREM_BITS;
  localparam int unsigned LB = bmpg_pkg::LEN_BITS;

  logic [1:0]    state;
  logic [LB-1:0] cnt;
  logic [PB-1:0] pos;
  logic [CB-1:0] col;
  logic [RB-1:0] row;
  logic [1:0]    chan;
  logic [7:0]    blue_q;
  logic [BB-1:0] blue_r;
  logic [7:0]    green_q;
  logic [GB-1:0] green_r;

  logic [PB-1:0] remain;
  logic [LB-1:0] n_calc;
  logic          emit;
  logic          in_header;
  logic [7:0]    byte_next;
  logic [BB:0]   bsum;
  logic [7:0]    blue_q_next;
  logic [BB-1:0] blue_r_next;
  logic [7:0]    green_q_next;
  logic [GB-1:0] green_r_next;

  assign cmd_ready = state == ST_IDLE;
  assign emit      = (state == ST_RUN) && (!out_valid || out_ready);
  assign in_header = pos < PB'(bmpg_pkg::HEADER_BYTES);
  assign remain    = PB'(bmpg_pkg::FILE_BYTES) - pos;
  assign n_calc    = (remain < PB'(cnt)) ? remain[LB-1:0] : cnt;
  assign status.busy = state != ST_IDLE;
  assign status.pos  = pos;

  always_comb begin
    if (in_header) begin
      byte_next = bmpg_pkg::header_byte(pos[5:0]);
    end else begin
      unique case (chan)
        bmpg_pkg::CH_BLUE:  byte_next = blue_q;
        bmpg_pkg::CH_GREEN: byte_next = green_q;
        default:            byte_next = 8'(col) + 8'(row);
      endcase
    end
  end

  always_comb begin
    bsum = {1'b0, blue_r} + (BB + 1)'(bmpg_pkg::BLUE_R);
    if (bsum >= (BB + 1)'(bmpg_pkg::IMAGE_WIDTH - 1)) begin
      blue_r_next = BB'(bsum - (BB + 1)'(bmpg_pkg::IMAGE_WIDTH - 1));
      blue_q_next = blue_q + 8'(bmpg_pkg::BLUE_Q) + 8'd1;
    end else begin
      blue_r_next = BB'(bsum);
      blue_q_next = blue_q + 8'(bmpg_pkg::BLUE_Q);
    end
    if (green_r >= GB'(bmpg_pkg::GREEN_R)) begin
      green_r_next = green_r - GB'(bmpg_pkg::GREEN_R);
      green_q_next = green_q - 8'(bmpg_pkg::GREEN_Q);
    end else begin
      green_r_next = green_r + GB'(bmpg_pkg::IMAGE_HEIGHT - 1 - bmpg_pkg::GREEN_R);
      green_q_next = green_q - 8'(bmpg_pkg::GREEN_Q) - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      pos       <= '0;
      col       <= '0;
      row       <= RB'(bmpg_pkg::IMAGE_HEIGHT - 1);
      chan      <= bmpg_pkg::CH_BLUE;
      blue_q    <= '0;
      blue_r    <= '0;
      green_q   <= 8'd255;
      green_r   <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cnt   <= cmd.len;
            state <= ST_CALC;
            if (cmd.restart) begin
              pos     <= '0;
              col     <= '0;
              row     <= RB'(bmpg_pkg::IMAGE_HEIGHT - 1);
              chan    <= bmpg_pkg::CH_BLUE;
              blue_q  <= '0;
              blue_r  <= '0;
              green_q <= 8'd255;
              green_r <= '0;
            end
          end
        end
        ST_CALC: begin
          cnt   <= n_calc;
          state <= (n_calc == '0) ? ST_IDLE : ST_RUN;
        end
        ST_RUN: begin
          if (emit) begin
            pos       <= pos + 1'b1;
            cnt       <= cnt - 1'b1;
            if (cnt == LB'(1)) begin
              state <= ST_IDLE;
            end
            if (!in_header) begin
              if (chan == bmpg_pkg::CH_RED) begin
                chan <= bmpg_pkg::CH_BLUE;
                if (col == CB'(bmpg_pkg::IMAGE_WIDTH - 1)) begin
                  col     <= '0;
                  blue_q  <= '0;
                  blue_r  <= '0;
                  row     <= row - 1'b1;
                  green_q <= green_q_next;
                  green_r <= green_r_next;
                end else begin
                  col    <= col + 1'b1;
                  blue_q <= blue_q_next;
                  blue_r <= blue_r_next;
                end
              end else begin
                chan <= chan + 2'd1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= byte_next;
      out_last <= cnt == LB'(1);
      out_eof  <= (pos + 1'b1) == PB'(bmpg_pkg::FILE_BYTES);
    end
  end

endmodule

// ===== design/bmp_test_pattern_byte_generator.sv =====
// Channel   Direction  tdata              tuser            tlast
// request   in         [6:0] max_len      restart          -
// bytes     out        [7:0] data_byte    end_of_file      last_in_packet
//
// A request is taken from the queue in the idle state and sized in the calc
// state, then one byte leaves per cycle while the output is not stalled.
// The byte sequencer in the back end sets this pace; two requests can wait in
// the queue meanwhile. Reset is synchronous and starts the file from offset zero.
// A stalled output holds its byte and stops the sequencer until it is taken.
module bmp_test_pattern_byte_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // [6:0] max_len, [7] zero
  input  logic       s_tuser,  // [0] restart
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,  // [7:0] data_byte
  output logic       m_tlast,
  output logic       m_tuser   // [0] end_of_file
);

  bmpg_pkg::cmd_t         front_cmd;
  bmpg_pkg::cmd_t         queue_cmd;
  bmpg_pkg::back_status_t back_status;
  logic                   front_valid;
  logic                   front_ready;
  logic                   queue_valid;
  logic                   queue_ready;

  bmpg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_restart (s_tuser),
    .in_len     (s_tdata[bmpg_pkg::LEN_BITS-1:0]),
    .cmd_valid  (front_valid),
    .cmd_ready  (front_ready),
    .cmd        (front_cmd)
  );

  bmpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (queue_valid),
    .rd_ready (queue_ready),
    .rd_data  (queue_cmd)
  );

  bmpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (queue_valid),
    .cmd_ready (queue_ready),
    .cmd       (queue_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast),
    .out_eof   (m_tuser),
    .status    (back_status)
  );

  // The final byte of the file always closes its transaction run.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tuser |-> m_tlast)
    else $error("end of file without last mark");

  assert property (@(posedge clk) rst |=> !m_tvalid && !back_status.busy)
    else $error("output or sequencer active after reset");

  assert property (@(posedge clk) disable iff (rst)
    back_status.pos <= bmpg_pkg::POS_BITS'(bmpg_pkg::FILE_BYTES))
    else $error("file position beyond end of file");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser |=> back_status.pos == bmpg_pkg::POS_BITS'(bmpg_pkg::FILE_BYTES)
      || back_status.busy)
    else $error("position moved after end of file without a restart");

endmodule
